FILE: design/keypad_matrix_debouncer_unit_macros.svh
`ifndef KEYPAD_MATRIX_DEBOUNCER_UNIT_MACROS_SVH
`define KEYPAD_MATRIX_DEBOUNCER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/kmd_pkg.sv
package kmd_pkg;

    localparam int TIME_W      = 16;
    localparam int ROW_IDX_W   = 3;
    localparam int COL_IDX_W   = 3;
    localparam int COL_FIELD_W = 8;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd20;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef struct packed {
        logic fire;
        logic pressed;
    } kmd_lane_t;

    typedef struct packed {
        logic                 event_valid;
        logic [ROW_IDX_W-1:0] event_row;
        logic [COL_IDX_W-1:0] event_column;
        logic                 event_pressed;
        logic [TIME_W-1:0]    event_time;
        logic                 event_waiting;
    } kmd_result_t;

endpackage

FILE: design/kmd_lane.sv
module kmd_lane #(
    parameter int ROWS = 8,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [ROW_W-1:0]          row_sel,
    input  logic                      level,
    input  logic [kmd_pkg::TIME_W-1:0] now_time,
    input  logic [kmd_pkg::TIME_W-1:0] debounce_time,
    output kmd_pkg::kmd_lane_t        status
);
    import kmd_pkg::*;

    logic              raw_reg    [ROWS];
    logic              stable_reg [ROWS];
    logic [TIME_W-1:0] stamp_reg  [ROWS];

    logic              raw_next;
    logic              stable_next;
    logic [TIME_W-1:0] stamp_next;
    logic [TIME_W-1:0] elapsed;
    logic              changed;
    logic              fire;

    always_comb
    begin
        raw_next    = ~level;
        changed     = raw_next != raw_reg[row_sel];
        stamp_next  = changed ? now_time : stamp_reg[row_sel];
        elapsed     = now_time - stamp_next;
        fire        = (elapsed >= debounce_time) && (stable_reg[row_sel] != raw_next);
        stable_next = fire ? raw_next : stable_reg[row_sel];
    end

    assign status.fire    = fire & en;
    assign status.pressed = raw_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                raw_reg[r]    <= 1'b0;
                stable_reg[r] <= 1'b0;
                stamp_reg[r]  <= '0;
            end
        end
        else if (en)
        begin
            raw_reg[row_sel]    <= raw_next;
            stable_reg[row_sel] <= stable_next;
            stamp_reg[row_sel]  <= stamp_next;
        end
    end

endmodule

FILE: design/kmd_merge.sv
module kmd_merge #(
    parameter int LANES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         mode,
    input  logic [kmd_pkg::ROW_IDX_W-1:0] key_row,
    input  logic [kmd_pkg::TIME_W-1:0]    now_time,
    input  kmd_pkg::kmd_lane_t           lane_status [LANES],
    output kmd_pkg::kmd_result_t         result
);
    import kmd_pkg::*;

    logic                 slot_full_reg;
    logic                 slot_full_next;
    logic [ROW_IDX_W-1:0] slot_row_reg;
    logic [COL_IDX_W-1:0] slot_column_reg;
    logic                 slot_pressed_reg;
    logic [TIME_W-1:0]    slot_time_reg;

    logic                 hit;
    logic [COL_IDX_W-1:0] hit_column;
    logic                 hit_pressed;
    logic                 fill;
    logic                 take;

    // lowest firing column wins
    always_comb
    begin
        hit         = 1'b0;
        hit_column  = '0;
        hit_pressed = 1'b0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (lane_status[i].fire)
            begin
                hit         = 1'b1;
                hit_column  = COL_IDX_W'(i);
                hit_pressed = lane_status[i].pressed;
            end
        end
    end

    always_comb
    begin
        fill = accept && (mode == MODE_SCAN) && hit && !slot_full_reg;
        take = accept && (mode == MODE_POLL) && slot_full_reg;
        if (fill)
            slot_full_next = 1'b1;
        else if (take)
            slot_full_next = 1'b0;
        else
            slot_full_next = slot_full_reg;
    end

    always_comb
    begin
        result = '0;
        if (mode == MODE_POLL)
        begin
            if (slot_full_reg)
            begin
                result.event_valid   = 1'b1;
                result.event_row     = slot_row_reg;
                result.event_column  = slot_column_reg;
                result.event_pressed = slot_pressed_reg;
                result.event_time    = slot_time_reg;
            end
        end
        else
        begin
            result.event_waiting = slot_full_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_full_reg <= 1'b0;
        else
            slot_full_reg <= slot_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            slot_row_reg     <= key_row;
            slot_column_reg  <= hit_column;
            slot_pressed_reg <= hit_pressed;
            slot_time_reg    <= now_time;
        end
    end

endmodule

FILE: design/keypad_matrix_debouncer_unit.sv
// Debounces every key of a ROWS x COLUMNS keypad matrix, one column lane per key column.
// Each request is either a row scan (key_row, active-low column_bits, millisecond now_time)
// or a poll that returns and clears the single pending key event; every request gives exactly
// one result. A request is taken every clock cycle while req_stall is low: all column lanes
// compare elapsed time against debounce_time and update their row's state in that same cycle,
// and the result is written to an output register backed by a one-entry skid stage, so
// req_stall rises only when both hold results that res_stall keeps waiting. Rows at or beyond
// ROWS are ignored, as are columns beyond eight. All key state sits in flip-flops cleared by
// reset; there is no clearing pass. Write debounce_time only while no request is in flight.
module keypad_matrix_debouncer_unit #(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            debounce_time_we,
    input  logic [kmd_pkg::TIME_W-1:0]      debounce_time,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            mode,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]   key_row,
    input  logic [kmd_pkg::COL_FIELD_W-1:0] column_bits,
    input  logic [kmd_pkg::TIME_W-1:0]      now_time,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            event_valid,
    output logic [kmd_pkg::ROW_IDX_W-1:0]   event_row,
    output logic [kmd_pkg::COL_IDX_W-1:0]   event_column,
    output logic                            event_pressed,
    output logic [kmd_pkg::TIME_W-1:0]      event_time,
    output logic                            event_waiting
);
    import kmd_pkg::*;

    localparam int LANES = (COLUMNS < COL_FIELD_W) ? COLUMNS : COL_FIELD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [TIME_W-1:0]    debounce_time_reg;
    logic [ROW_IDX_W+1:0] row_wide;
    logic                 row_ok;
    logic [ROW_W-1:0]     row_sel;
    logic                 accept;
    logic                 lane_en;
    kmd_lane_t            lane_status [LANES];
    kmd_result_t          result;

    kmd_result_t          out_reg;
    kmd_result_t          skid_reg;
    logic                 res_valid_reg;
    logic                 skid_valid_reg;
    logic                 out_take;

    assign row_wide  = {2'b00, key_row};
    assign row_ok    = row_wide < (ROW_IDX_W + 2)'(ROWS);
    assign row_sel   = ROW_W'(key_row);
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign lane_en   = accept && (mode == MODE_SCAN) && row_ok;
    assign out_take  = res_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_time_reg <= DEBOUNCE_RESET;
        else if (debounce_time_we)
            debounce_time_reg <= debounce_time;
    end

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        kmd_lane #(
            .ROWS (ROWS)
        ) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (lane_en),
            .row_sel       (row_sel),
            .level         (column_bits[c]),
            .now_time      (now_time),
            .debounce_time (debounce_time_reg),
            .status        (lane_status[c])
        );
    end

    kmd_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .key_row     (key_row),
        .now_time    (now_time),
        .lane_status (lane_status),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (res_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                res_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (res_valid_reg && !out_take)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    assign res_valid     = res_valid_reg;
    assign event_valid   = out_reg.event_valid;
    assign event_row     = out_reg.event_row;
    assign event_column  = out_reg.event_column;
    assign event_pressed = out_reg.event_pressed;
    assign event_time    = out_reg.event_time;
    assign event_waiting = out_reg.event_waiting;

endmodule

FILE: design/kmd_checker.sv
`include "keypad_matrix_debouncer_unit_macros.svh"

module kmd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            debounce_time_we,
    input logic [kmd_pkg::TIME_W-1:0]      debounce_time,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            mode,
    input logic [kmd_pkg::ROW_IDX_W-1:0]   key_row,
    input logic [kmd_pkg::COL_FIELD_W-1:0] column_bits,
    input logic [kmd_pkg::TIME_W-1:0]      now_time,
    input logic                            res_valid,
    input logic                            res_stall,
    input logic                            event_valid,
    input logic [kmd_pkg::ROW_IDX_W-1:0]   event_row,
    input logic [kmd_pkg::COL_IDX_W-1:0]   event_column,
    input logic                            event_pressed,
    input logic [kmd_pkg::TIME_W-1:0]      event_time,
    input logic                            event_waiting
);

    // hold a stalled result
    `KMD_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(event_valid) && $stable(event_time) && $stable(event_waiting),
        "stalled result changed")

    // a delivered event leaves the slot empty
    `KMD_ASSERT_NOW(a_poll_clears, res_valid && event_valid, !event_waiting,
        "slot still full after returning its event")

    // no event, no payload
    `KMD_ASSERT_NOW(a_empty_zero, res_valid && !event_valid,
        event_row == 3'd0 && event_column == 3'd0 && !event_pressed && event_time == 16'd0,
        "event fields set without an event")

    // stall a request only behind a waiting result
    `KMD_ASSERT_NOW(a_stall_cause, req_stall, res_valid,
        "request stalled with no result waiting")

endmodule

bind keypad_matrix_debouncer_unit kmd_checker u_kmd_checker (.*);

FILE: dv/kmd_event_checker.sv
`timescale 1ns / 100ps

module kmd_event_checker #(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            debounce_time_we,
    input  logic [kmd_pkg::TIME_W-1:0]      debounce_time,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic                            mode,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]   key_row,
    input  logic [kmd_pkg::COL_FIELD_W-1:0] column_bits,
    input  logic [kmd_pkg::TIME_W-1:0]      now_time,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic                            event_valid,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]   event_row,
    input  logic [kmd_pkg::COL_IDX_W-1:0]   event_column,
    input  logic                            event_pressed,
    input  logic [kmd_pkg::TIME_W-1:0]      event_time,
    input  logic                            event_waiting,
    output int                              fail_count,
    output int                              pending
);

    localparam int MAX_REPORTS = 10;

    logic [kmd_pkg::TIME_W-1:0]      debounce_ms;
    logic [kmd_pkg::COL_FIELD_W-1:0] raw_keys [ROWS];
    logic [kmd_pkg::COL_FIELD_W-1:0] stable_keys [ROWS];
    logic [kmd_pkg::TIME_W-1:0]      key_stamp [ROWS][kmd_pkg::COL_FIELD_W];

    logic                            slot_full;
    logic [kmd_pkg::ROW_IDX_W-1:0]   slot_row;
    logic [kmd_pkg::COL_IDX_W-1:0]   slot_column;
    logic                            slot_pressed;
    logic [kmd_pkg::TIME_W-1:0]      slot_time;

    kmd_pkg::kmd_result_t expected_events [$];
    int mismatches = 0;

    assign fail_count = mismatches;

    task automatic predict_key_event(
        input  logic                            req_mode,
        input  logic [kmd_pkg::ROW_IDX_W-1:0]   req_row,
        input  logic [kmd_pkg::COL_FIELD_W-1:0] req_cols,
        input  logic [kmd_pkg::TIME_W-1:0]      req_ms,
        output kmd_pkg::kmd_result_t            want
    );
        int c;
        logic level;
        logic [kmd_pkg::TIME_W-1:0] elapsed;
        want = '0;
        if (req_mode == kmd_pkg::MODE_SCAN)
        begin
            if (int'(req_row) < ROWS)
            begin
                for (c = 0; c < COLUMNS && c < kmd_pkg::COL_FIELD_W; c++)
                begin
                    level = ~req_cols[c];
                    if (level != raw_keys[req_row][c])
                    begin
                        raw_keys[req_row][c] = level;
                        key_stamp[req_row][c] = req_ms;
                    end
                    elapsed = req_ms - key_stamp[req_row][c];
                    if (elapsed >= debounce_ms && stable_keys[req_row][c] != raw_keys[req_row][c])
                    begin
                        stable_keys[req_row][c] = raw_keys[req_row][c];
                        if (!slot_full)
                        begin
                            slot_full    = 1'b1;
                            slot_row     = req_row;
                            slot_column  = c[kmd_pkg::COL_IDX_W-1:0];
                            slot_pressed = raw_keys[req_row][c];
                            slot_time    = req_ms;
                        end
                    end
                end
            end
            want.event_waiting = slot_full;
        end
        else if (slot_full)
        begin
            want.event_valid   = 1'b1;
            want.event_row     = slot_row;
            want.event_column  = slot_column;
            want.event_pressed = slot_pressed;
            want.event_time    = slot_time;
            slot_full    = 1'b0;
            slot_row     = '0;
            slot_column  = '0;
            slot_pressed = 1'b0;
            slot_time    = '0;
        end
    endtask

    task automatic report_mismatch(
        input string                what,
        input kmd_pkg::kmd_result_t want,
        input kmd_pkg::kmd_result_t got
    );
        if (mismatches < MAX_REPORTS)
        begin
            $display("%0t %s: expected valid=%0b row=%0d column=%0d pressed=%0b time=%0d waiting=%0b",
                     $realtime, what, want.event_valid, want.event_row, want.event_column,
                     want.event_pressed, want.event_time, want.event_waiting);
            $display("    got valid=%0b row=%0d column=%0d pressed=%0b time=%0d waiting=%0b",
                     got.event_valid, got.event_row, got.event_column,
                     got.event_pressed, got.event_time, got.event_waiting);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kmd_pkg::kmd_result_t want;
        kmd_pkg::kmd_result_t got;
        if (!rst_n)
        begin
            debounce_ms = kmd_pkg::DEBOUNCE_RESET;
            for (int r = 0; r < ROWS; r++)
            begin
                raw_keys[r]    = '0;
                stable_keys[r] = '0;
                for (int c = 0; c < kmd_pkg::COL_FIELD_W; c++)
                begin
                    key_stamp[r][c] = '0;
                end
            end
            slot_full    = 1'b0;
            slot_row     = '0;
            slot_column  = '0;
            slot_pressed = 1'b0;
            slot_time    = '0;
            expected_events.delete();
            pending <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got = {event_valid, event_row, event_column, event_pressed,
                       event_time, event_waiting};
                if (expected_events.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", '0, got);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.event_valid !== want.event_valid
                        || got.event_row !== want.event_row
                        || got.event_column !== want.event_column
                        || got.event_pressed !== want.event_pressed
                        || got.event_time !== want.event_time
                        || got.event_waiting !== want.event_waiting)
                    begin
                        report_mismatch("key event mismatch", want, got);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_key_event(mode, key_row, column_bits, now_time, want);
                expected_events.push_back(want);
            end
            if (debounce_time_we)
            begin
                debounce_ms = debounce_time;
            end
            pending <= expected_events.size();
        end
    end

endmodule

FILE: dv/keypad_matrix_debouncer_unit_tb.sv
`timescale 1ns / 100ps

module keypad_matrix_debouncer_unit_tb;

    localparam int ROWS        = 8;
    localparam int COLUMNS     = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 265;
    localparam int HOLD_CYCLES = 60;

    logic                            clk;
    logic                            rst_n;
    logic                            debounce_time_we;
    logic [kmd_pkg::TIME_W-1:0]      debounce_time;
    logic                            req_valid;
    logic                            req_stall;
    logic                            mode;
    logic [kmd_pkg::ROW_IDX_W-1:0]   key_row;
    logic [kmd_pkg::COL_FIELD_W-1:0] column_bits;
    logic [kmd_pkg::TIME_W-1:0]      now_time;
    logic                            res_valid;
    logic                            res_stall;
    logic                            event_valid;
    logic [kmd_pkg::ROW_IDX_W-1:0]   event_row;
    logic [kmd_pkg::COL_IDX_W-1:0]   event_column;
    logic                            event_pressed;
    logic [kmd_pkg::TIME_W-1:0]      event_time;
    logic                            event_waiting;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int requests_sent = 0;

    logic steady = 1'b0;
    logic hold_off_go = 1'b0;

    logic [kmd_pkg::TIME_W-1:0]      scan_ms;
    logic [kmd_pkg::ROW_IDX_W-1:0]   scan_row;
    logic [kmd_pkg::COL_FIELD_W-1:0] row_hold [ROWS];

    keypad_matrix_debouncer_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .debounce_time_we (debounce_time_we),
        .debounce_time    (debounce_time),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .mode             (mode),
        .key_row          (key_row),
        .column_bits      (column_bits),
        .now_time         (now_time),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .event_valid      (event_valid),
        .event_row        (event_row),
        .event_column     (event_column),
        .event_pressed    (event_pressed),
        .event_time       (event_time),
        .event_waiting    (event_waiting)
    );

    kmd_event_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .debounce_time_we (debounce_time_we),
        .debounce_time    (debounce_time),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .mode             (mode),
        .key_row          (key_row),
        .column_bits      (column_bits),
        .now_time         (now_time),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .event_valid      (event_valid),
        .event_row        (event_row),
        .event_column     (event_column),
        .event_pressed    (event_pressed),
        .event_time       (event_time),
        .event_waiting    (event_waiting),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keypad_matrix_debouncer_unit_tb: FAIL");
            $finish;
        end
    end

    // hold results back for a long stretch once asked, otherwise stall at random unless steady
    initial
    begin
        int held;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                res_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                res_stall <= 1'b0;
            end
            else
            begin
                res_stall <= !steady && ($urandom_range(0, 99) < 23);
            end
        end
    end

    task automatic offer_request(
        input logic                            req_mode,
        input logic [kmd_pkg::ROW_IDX_W-1:0]   req_row,
        input logic [kmd_pkg::COL_FIELD_W-1:0] req_cols,
        input logic [kmd_pkg::TIME_W-1:0]      req_ms
    );
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        mode        <= req_mode;
        key_row     <= req_row;
        column_bits <= req_cols;
        now_time    <= req_ms;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        requests_sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_debounce(input logic [kmd_pkg::TIME_W-1:0] value);
        drain_results();
        debounce_time_we <= 1'b1;
        debounce_time    <= value;
        @(posedge clk);
        debounce_time_we <= 1'b0;
    endtask

    task automatic random_request();
        int roll;
        logic [kmd_pkg::ROW_IDX_W-1:0]   r;
        logic [kmd_pkg::COL_FIELD_W-1:0] cols;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            offer_request(kmd_pkg::MODE_POLL, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        else if (roll < 33)
        begin
            offer_request(kmd_pkg::MODE_SCAN, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        else if (roll < 36)
        begin
            // change a key, then rescan just short of a full wrap of the timer
            r = 3'($urandom_range(0, 7));
            row_hold[r] = row_hold[r] ^ (8'h01 << $urandom_range(0, 7));
            offer_request(kmd_pkg::MODE_SCAN, r, row_hold[r], scan_ms);
            offer_request(kmd_pkg::MODE_SCAN, r, row_hold[r], scan_ms - 16'd1);
        end
        else
        begin
            scan_ms = scan_ms + 16'($urandom_range(0, 6));
            if ($urandom_range(0, 99) < 6)
            begin
                row_hold[scan_row] = row_hold[scan_row] ^ (8'h01 << $urandom_range(0, 7));
            end
            cols = row_hold[scan_row];
            if ($urandom_range(0, 3) == 0)
            begin
                cols = cols ^ (8'h01 << $urandom_range(0, 7));
            end
            offer_request(kmd_pkg::MODE_SCAN, scan_row, cols, scan_ms);
            scan_row = scan_row + 1'b1;
        end
    endtask

    initial
    begin
        int plan [6];
        int phase;
        int target;
        rst_n            <= 1'b0;
        debounce_time_we <= 1'b0;
        debounce_time    <= '0;
        req_valid        <= 1'b0;
        mode             <= kmd_pkg::MODE_SCAN;
        key_row          <= '0;
        column_bits      <= '1;
        now_time         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(kmd_pkg::MODE_POLL, 3'd7, 8'h00, 16'hFFFF);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFE, 16'd100);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFE, 16'd119);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFE, 16'd120);
        offer_request(kmd_pkg::MODE_SCAN, 3'd1, 8'h00, 16'd120);
        offer_request(kmd_pkg::MODE_SCAN, 3'd1, 8'h00, 16'd140);
        offer_request(kmd_pkg::MODE_POLL, 3'd0, 8'hFF, 16'd0);
        offer_request(kmd_pkg::MODE_POLL, 3'd5, 8'h5A, 16'h1234);
        offer_request(kmd_pkg::MODE_SCAN, 3'd7, 8'h7F, 16'd65530);
        offer_request(kmd_pkg::MODE_SCAN, 3'd7, 8'h7F, 16'd14);
        offer_request(kmd_pkg::MODE_POLL, 3'd2, 8'hA5, 16'hFFFF);
        // bounce on release: raw flips back before the time has run
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFF, 16'd200);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFE, 16'd205);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFF, 16'd210);
        offer_request(kmd_pkg::MODE_SCAN, 3'd0, 8'hFF, 16'd230);
        offer_request(kmd_pkg::MODE_POLL, 3'd0, 8'h00, 16'd0);
        offer_request(kmd_pkg::MODE_SCAN, 3'd1, 8'hFF, 16'd0);
        offer_request(kmd_pkg::MODE_SCAN, 3'd1, 8'hFF, 16'hFFFF);
        offer_request(kmd_pkg::MODE_POLL, 3'd3, 8'h3C, 16'h8000);
        offer_request(kmd_pkg::MODE_SCAN, 3'd3, 8'hAA, 16'h5555);
        offer_request(kmd_pkg::MODE_SCAN, 3'd3, 8'h55, 16'hAAAA);
        offer_request(kmd_pkg::MODE_POLL, 3'd4, 8'hC3, 16'h7FFF);
        offer_request(kmd_pkg::MODE_POLL, 3'd6, 8'h81, 16'h0001);

        plan = '{0, 65535, 1, 7, 20, 0};
        plan[5] = $urandom_range(2, 40);
        scan_ms = 16'($urandom_range(0, 65535));
        scan_row = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            row_hold[r] = 8'hFF;
        end

        for (phase = 0; phase < 6; phase++)
        begin
            set_debounce(16'(plan[phase]));
            steady = (phase == 2);
            if (phase == 3)
            begin
                hold_off_go = 1'b1;
            end
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target)
            begin
                random_request();
            end
        end
        drain_results();

        if (fail_count == 0)
        begin
            $display("keypad_matrix_debouncer_unit_tb: PASS");
        end
        else
        begin
            $display("keypad_matrix_debouncer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/kmd_pkg.sv
design/kmd_lane.sv
design/kmd_merge.sv
design/keypad_matrix_debouncer_unit.sv
design/kmd_checker.sv
dv/kmd_event_checker.sv
dv/keypad_matrix_debouncer_unit_tb.sv
